>>> rtl/core/ofsl_pkg.sv
// ----------------------------------------------------------------------------
// Object file section loader package
// Shared widths, header bytes, parser phase codes and the result word type.
// ----------------------------------------------------------------------------
package ofsl_pkg;

    localparam int BYTE_W  = 8;
    localparam int WORD_W  = 16;
    localparam int PHASE_W = 4;
    localparam int KIND_W  = 2;

    localparam logic [PHASE_W-1:0] PH_PAIR_FIRST  = 4'd0;
    localparam logic [PHASE_W-1:0] PH_PAIR_SECOND = 4'd1;
    localparam logic [PHASE_W-1:0] PH_ADDR_HI     = 4'd2;
    localparam logic [PHASE_W-1:0] PH_ADDR_LO     = 4'd3;
    localparam logic [PHASE_W-1:0] PH_COUNT_HI    = 4'd4;
    localparam logic [PHASE_W-1:0] PH_COUNT_LO    = 4'd5;
    localparam logic [PHASE_W-1:0] PH_WORD_HI     = 4'd6;
    localparam logic [PHASE_W-1:0] PH_WORD_LO     = 4'd7;
    localparam logic [PHASE_W-1:0] PH_SYMADDR_HI  = 4'd8;
    localparam logic [PHASE_W-1:0] PH_SYMADDR_LO  = 4'd9;
    localparam logic [PHASE_W-1:0] PH_SKIP        = 4'd10;

    localparam logic [KIND_W-1:0] KIND_CODE   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DATA   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SYMBOL = 2'd2;
    localparam logic [KIND_W-1:0] KIND_FILE   = 2'd3;

    localparam logic [BYTE_W-1:0] HDR_CODE_0 = 8'hCA;
    localparam logic [BYTE_W-1:0] HDR_CODE_1 = 8'hDE;
    localparam logic [BYTE_W-1:0] HDR_DATA_0 = 8'hDA;
    localparam logic [BYTE_W-1:0] HDR_DATA_1 = 8'hDA;
    localparam logic [BYTE_W-1:0] HDR_SYM_0  = 8'hC3;
    localparam logic [BYTE_W-1:0] HDR_SYM_1  = 8'hB7;
    localparam logic [BYTE_W-1:0] HDR_FILE_0 = 8'hF1;
    localparam logic [BYTE_W-1:0] HDR_FILE_1 = 8'h7E;
    localparam logic [BYTE_W-1:0] HDR_LINE_0 = 8'h71;
    localparam logic [BYTE_W-1:0] HDR_LINE_1 = 8'h5E;

    localparam logic [WORD_W-1:0] LINE_SKIP_BYTES = 16'd6;

    typedef struct packed {
        logic [WORD_W-1:0] address;
        logic [WORD_W-1:0] data;
    } ofsl_write_t;

endpackage

>>> rtl/core/ofsl_in_stage.sv
// ----------------------------------------------------------------------------
// Input register
// Holds one stream byte request until the parser consumes it.
// ----------------------------------------------------------------------------
module ofsl_in_stage (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [ofsl_pkg::BYTE_W-1:0] s_byte,
    input  logic                       advance,
    output logic                       byte_valid,
    output logic [ofsl_pkg::BYTE_W-1:0] byte_data
);

    logic                        valid_reg;
    logic                        valid_next;
    logic [ofsl_pkg::BYTE_W-1:0] byte_reg;

    assign s_ready    = !valid_reg || advance;
    assign valid_next = s_ready ? s_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            byte_reg <= s_byte;
        end
    end

    assign byte_valid = valid_reg;
    assign byte_data  = byte_reg;

endmodule

>>> rtl/core/ofsl_parser.sv
// ----------------------------------------------------------------------------
// Section parser
// Phase machine that recognizes section headers, tracks the load address
// and count, and assembles big-endian words into memory writes.
// ----------------------------------------------------------------------------
module ofsl_parser (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        advance,
    input  logic [ofsl_pkg::BYTE_W-1:0] byte_data,
    output logic                        write_valid,
    output ofsl_pkg::ofsl_write_t       write_req
);

    logic [ofsl_pkg::PHASE_W-1:0] phase_reg, phase_next;
    logic [ofsl_pkg::BYTE_W-1:0]  held_reg, held_next;
    logic [ofsl_pkg::KIND_W-1:0]  kind_reg, kind_next;
    logic [ofsl_pkg::WORD_W-1:0]  addr_reg, addr_next;
    logic [ofsl_pkg::WORD_W-1:0]  count_reg, count_next;
    logic [ofsl_pkg::WORD_W-1:0]  count_dec;

    assign count_dec = count_reg - ofsl_pkg::WORD_W'(1);

    always_comb begin
        phase_next  = phase_reg;
        held_next   = held_reg;
        kind_next   = kind_reg;
        addr_next   = addr_reg;
        count_next  = count_reg;
        write_valid = 1'b0;
        write_req.address = addr_reg;
        write_req.data    = {held_reg, byte_data};
        case (phase_reg)
            ofsl_pkg::PH_PAIR_SECOND: begin
                phase_next = ofsl_pkg::PH_PAIR_FIRST;
                if (held_reg == ofsl_pkg::HDR_CODE_0 && byte_data == ofsl_pkg::HDR_CODE_1) begin
                    kind_next  = ofsl_pkg::KIND_CODE;
                    phase_next = ofsl_pkg::PH_ADDR_HI;
                end else if (held_reg == ofsl_pkg::HDR_DATA_0
                             && byte_data == ofsl_pkg::HDR_DATA_1) begin
                    kind_next  = ofsl_pkg::KIND_DATA;
                    phase_next = ofsl_pkg::PH_ADDR_HI;
                end else if (held_reg == ofsl_pkg::HDR_SYM_0
                             && byte_data == ofsl_pkg::HDR_SYM_1) begin
                    kind_next  = ofsl_pkg::KIND_SYMBOL;
                    phase_next = ofsl_pkg::PH_SYMADDR_HI;
                end else if (held_reg == ofsl_pkg::HDR_FILE_0
                             && byte_data == ofsl_pkg::HDR_FILE_1) begin
                    kind_next  = ofsl_pkg::KIND_FILE;
                    phase_next = ofsl_pkg::PH_COUNT_HI;
                end else if (held_reg == ofsl_pkg::HDR_LINE_0
                             && byte_data == ofsl_pkg::HDR_LINE_1) begin
                    count_next = ofsl_pkg::LINE_SKIP_BYTES;
                    phase_next = ofsl_pkg::PH_SKIP;
                end
            end
            ofsl_pkg::PH_ADDR_HI: begin
                addr_next  = {byte_data, 8'h00};
                phase_next = ofsl_pkg::PH_ADDR_LO;
            end
            ofsl_pkg::PH_ADDR_LO: begin
                addr_next  = {addr_reg[15:8], byte_data};
                phase_next = ofsl_pkg::PH_COUNT_HI;
            end
            ofsl_pkg::PH_SYMADDR_HI: begin
                phase_next = ofsl_pkg::PH_SYMADDR_LO;
            end
            ofsl_pkg::PH_SYMADDR_LO: begin
                phase_next = ofsl_pkg::PH_COUNT_HI;
            end
            ofsl_pkg::PH_COUNT_HI: begin
                count_next = {byte_data, 8'h00};
                phase_next = ofsl_pkg::PH_COUNT_LO;
            end
            ofsl_pkg::PH_COUNT_LO: begin
                count_next = {count_reg[15:8], byte_data};
                if (count_next == '0) begin
                    phase_next = ofsl_pkg::PH_PAIR_FIRST;
                end else if (kind_reg == ofsl_pkg::KIND_CODE
                             || kind_reg == ofsl_pkg::KIND_DATA) begin
                    phase_next = ofsl_pkg::PH_WORD_HI;
                end else begin
                    phase_next = ofsl_pkg::PH_SKIP;
                end
            end
            ofsl_pkg::PH_WORD_HI: begin
                held_next  = byte_data;
                phase_next = ofsl_pkg::PH_WORD_LO;
            end
            ofsl_pkg::PH_WORD_LO: begin
                write_valid = 1'b1;
                addr_next   = addr_reg + ofsl_pkg::WORD_W'(1);
                count_next  = count_dec;
                phase_next  = (count_dec == '0) ? ofsl_pkg::PH_PAIR_FIRST
                                                : ofsl_pkg::PH_WORD_HI;
            end
            ofsl_pkg::PH_SKIP: begin
                count_next = count_dec;
                if (count_dec == '0) begin
                    phase_next = ofsl_pkg::PH_PAIR_FIRST;
                end
            end
            default: begin
                held_next  = byte_data;
                phase_next = ofsl_pkg::PH_PAIR_SECOND;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= ofsl_pkg::PH_PAIR_FIRST;
            held_reg  <= '0;
            kind_reg  <= ofsl_pkg::KIND_CODE;
            addr_reg  <= '0;
            count_reg <= '0;
        end else if (advance) begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
            kind_reg  <= kind_next;
            addr_reg  <= addr_next;
            count_reg <= count_next;
        end
    end

endmodule

>>> rtl/core/ofsl_out_stage.sv
// ----------------------------------------------------------------------------
// Result register
// Holds one memory write request until the downstream side takes it.
// ----------------------------------------------------------------------------
module ofsl_out_stage (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        byte_valid,
    input  logic                        write_valid,
    input  ofsl_pkg::ofsl_write_t       write_req,
    output logic                        advance,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [ofsl_pkg::WORD_W-1:0] m_write_address,
    output logic [ofsl_pkg::WORD_W-1:0] m_write_data
);

    logic                  valid_reg;
    logic                  valid_next;
    ofsl_pkg::ofsl_write_t write_reg;

    assign advance    = byte_valid && (!valid_reg || m_ready);
    assign valid_next = advance ? write_valid : (valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && write_valid) begin
            write_reg <= write_req;
        end
    end

    assign m_valid         = valid_reg;
    assign m_write_address = write_reg.address;
    assign m_write_data    = write_reg.data;

endmodule

>>> rtl/core/object_file_section_loader.sv
// ----------------------------------------------------------------------------
// Object file section loader
// A memory write goes from the input register through the parser into the
// result register. Throughput: one stream byte per cycle, set by the single
// parser pass, while the result register is empty or m_ready is high.
// Reset: synchronous, active low; clears both valid flags and parser state.
// ----------------------------------------------------------------------------
module object_file_section_loader (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [ofsl_pkg::BYTE_W-1:0] s_stream_byte,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [ofsl_pkg::WORD_W-1:0] m_write_address,
    output logic [ofsl_pkg::WORD_W-1:0] m_write_data
);

    logic                        advance;
    logic                        byte_valid;
    logic [ofsl_pkg::BYTE_W-1:0] byte_data;
    logic                        write_valid;
    ofsl_pkg::ofsl_write_t       write_req;

    ofsl_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_byte     (s_stream_byte),
        .advance    (advance),
        .byte_valid (byte_valid),
        .byte_data  (byte_data)
    );

    ofsl_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance     (advance),
        .byte_data   (byte_data),
        .write_valid (write_valid),
        .write_req   (write_req)
    );

    ofsl_out_stage u_out (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .byte_valid      (byte_valid),
        .write_valid     (write_valid),
        .write_req       (write_req),
        .advance         (advance),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_write_address (m_write_address),
        .m_write_data    (m_write_data)
    );

endmodule

>>> tb/tb_object_file_section_loader.sv
// ----------------------------------------------------------------------------
// Object file section loader testbench
// Sends object file bytes as requests and checks every memory write that the
// loader emits, in order, against a predictor of the section parser. Directed
// sections come first, then output back-pressure, a drain pause, random
// well-formed and broken streams, and a last stretch at full rate.
// ----------------------------------------------------------------------------
module tb_object_file_section_loader;

    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int RANDOM_BYTES    = 1000;
    localparam int FULL_RATE_BYTES = 100;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int SETTLE_CYCLES   = 10;

    logic                          aclk;
    logic                          aresetn;
    logic                          s_valid;
    logic                          s_ready;
    logic [ofsl_pkg::BYTE_W-1:0]   s_stream_byte;
    logic                          m_valid;
    logic                          m_ready;
    logic [ofsl_pkg::WORD_W-1:0]   m_write_address;
    logic [ofsl_pkg::WORD_W-1:0]   m_write_data;

    logic [ofsl_pkg::PHASE_W-1:0]  exp_phase = ofsl_pkg::PH_PAIR_FIRST;
    logic [ofsl_pkg::BYTE_W-1:0]   exp_held  = '0;
    logic [ofsl_pkg::KIND_W-1:0]   exp_kind  = ofsl_pkg::KIND_CODE;
    logic [ofsl_pkg::WORD_W-1:0]   exp_addr  = '0;
    logic [ofsl_pkg::WORD_W-1:0]   exp_count = '0;
    ofsl_pkg::ofsl_write_t         pending_writes[$];

    int error_count       = 0;
    int bytes_sent        = 0;
    int idle_cycles       = 0;
    int ready_hold_cycles = 0;
    bit src_gaps_on       = 1'b0;
    bit snk_stalls_on     = 1'b0;

    object_file_section_loader DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_stream_byte   (s_stream_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_write_address (m_write_address),
        .m_write_data    (m_write_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic track_stream_byte(input logic [ofsl_pkg::BYTE_W-1:0] b);
        ofsl_pkg::ofsl_write_t wr;
        case (exp_phase)
            ofsl_pkg::PH_PAIR_SECOND: begin
                exp_phase = ofsl_pkg::PH_PAIR_FIRST;
                if (exp_held == ofsl_pkg::HDR_CODE_0 && b == ofsl_pkg::HDR_CODE_1) begin
                    exp_kind  = ofsl_pkg::KIND_CODE;
                    exp_phase = ofsl_pkg::PH_ADDR_HI;
                end else if (exp_held == ofsl_pkg::HDR_DATA_0
                             && b == ofsl_pkg::HDR_DATA_1) begin
                    exp_kind  = ofsl_pkg::KIND_DATA;
                    exp_phase = ofsl_pkg::PH_ADDR_HI;
                end else if (exp_held == ofsl_pkg::HDR_SYM_0
                             && b == ofsl_pkg::HDR_SYM_1) begin
                    exp_kind  = ofsl_pkg::KIND_SYMBOL;
                    exp_phase = ofsl_pkg::PH_SYMADDR_HI;
                end else if (exp_held == ofsl_pkg::HDR_FILE_0
                             && b == ofsl_pkg::HDR_FILE_1) begin
                    exp_kind  = ofsl_pkg::KIND_FILE;
                    exp_phase = ofsl_pkg::PH_COUNT_HI;
                end else if (exp_held == ofsl_pkg::HDR_LINE_0
                             && b == ofsl_pkg::HDR_LINE_1) begin
                    exp_count = ofsl_pkg::LINE_SKIP_BYTES;
                    exp_phase = ofsl_pkg::PH_SKIP;
                end
            end
            ofsl_pkg::PH_ADDR_HI: begin
                exp_addr  = {b, 8'h00};
                exp_phase = ofsl_pkg::PH_ADDR_LO;
            end
            ofsl_pkg::PH_ADDR_LO: begin
                exp_addr[7:0] = b;
                exp_phase     = ofsl_pkg::PH_COUNT_HI;
            end
            ofsl_pkg::PH_SYMADDR_HI: begin
                exp_phase = ofsl_pkg::PH_SYMADDR_LO;
            end
            ofsl_pkg::PH_SYMADDR_LO: begin
                exp_phase = ofsl_pkg::PH_COUNT_HI;
            end
            ofsl_pkg::PH_COUNT_HI: begin
                exp_count = {b, 8'h00};
                exp_phase = ofsl_pkg::PH_COUNT_LO;
            end
            ofsl_pkg::PH_COUNT_LO: begin
                exp_count[7:0] = b;
                if (exp_count == '0) begin
                    exp_phase = ofsl_pkg::PH_PAIR_FIRST;
                end else if (exp_kind == ofsl_pkg::KIND_CODE
                             || exp_kind == ofsl_pkg::KIND_DATA) begin
                    exp_phase = ofsl_pkg::PH_WORD_HI;
                end else begin
                    exp_phase = ofsl_pkg::PH_SKIP;
                end
            end
            ofsl_pkg::PH_WORD_HI: begin
                exp_held  = b;
                exp_phase = ofsl_pkg::PH_WORD_LO;
            end
            ofsl_pkg::PH_WORD_LO: begin
                wr.address = exp_addr;
                wr.data    = {exp_held, b};
                pending_writes.push_back(wr);
                exp_addr  = exp_addr + ofsl_pkg::WORD_W'(1);
                exp_count = exp_count - ofsl_pkg::WORD_W'(1);
                exp_phase = (exp_count == '0) ? ofsl_pkg::PH_PAIR_FIRST
                                              : ofsl_pkg::PH_WORD_HI;
            end
            ofsl_pkg::PH_SKIP: begin
                exp_count = exp_count - ofsl_pkg::WORD_W'(1);
                if (exp_count == '0) begin
                    exp_phase = ofsl_pkg::PH_PAIR_FIRST;
                end
            end
            default: begin
                exp_held  = b;
                exp_phase = ofsl_pkg::PH_PAIR_SECOND;
            end
        endcase
    endtask

    // Called just after a falling edge; returns just after the falling edge
    // that follows acceptance, with valid still high.
    task automatic send_byte(input logic [ofsl_pkg::BYTE_W-1:0] b);
        int gap;
        if (src_gaps_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 5);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_stream_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        track_stream_byte(b);
        bytes_sent++;
        @(negedge aclk);
    endtask

    task automatic send_word(input logic [ofsl_pkg::WORD_W-1:0] w);
        send_byte(w[15:8]);
        send_byte(w[7:0]);
    endtask

    task automatic drain_writes();
        s_valid <= 1'b0;
        while (pending_writes.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic logic [ofsl_pkg::BYTE_W-1:0] random_stream_byte();
        case ($urandom_range(0, 9))
            0: return ofsl_pkg::HDR_CODE_0;
            1: return ofsl_pkg::HDR_DATA_0;
            2: return ofsl_pkg::HDR_SYM_1;
            3: return ofsl_pkg::HDR_LINE_0;
            default: return ofsl_pkg::BYTE_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic int random_count();
        int roll;
        roll = $urandom_range(0, 19);
        if (roll < 2) return 0;
        if (roll == 19) return $urandom_range(16, 48);
        return $urandom_range(1, 6);
    endfunction

    task automatic send_random_section();
        int pick;
        int n;
        int guard;
        logic [ofsl_pkg::WORD_W-1:0] base;
        guard = 0;
        while (exp_phase != ofsl_pkg::PH_PAIR_FIRST && guard < 64) begin
            send_byte(random_stream_byte());
            guard++;
        end
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            if (pick < 25) begin
                send_byte(ofsl_pkg::HDR_CODE_0);
                send_byte(ofsl_pkg::HDR_CODE_1);
            end else begin
                send_byte(ofsl_pkg::HDR_DATA_0);
                send_byte(ofsl_pkg::HDR_DATA_1);
            end
            if ($urandom_range(0, 5) == 0) begin
                base = ofsl_pkg::WORD_W'($urandom_range(16'hFFF8, 16'hFFFF));
            end else begin
                base = ofsl_pkg::WORD_W'($urandom);
            end
            n = random_count();
            send_word(base);
            send_word(ofsl_pkg::WORD_W'(n));
            repeat (n) send_word(ofsl_pkg::WORD_W'($urandom));
        end else if (pick < 60) begin
            send_byte(ofsl_pkg::HDR_SYM_0);
            send_byte(ofsl_pkg::HDR_SYM_1);
            send_word(ofsl_pkg::WORD_W'($urandom));
            n = $urandom_range(0, 6);
            send_word(ofsl_pkg::WORD_W'(n));
            repeat (n) send_byte(random_stream_byte());
        end else if (pick < 70) begin
            send_byte(ofsl_pkg::HDR_FILE_0);
            send_byte(ofsl_pkg::HDR_FILE_1);
            n = $urandom_range(0, 6);
            send_word(ofsl_pkg::WORD_W'(n));
            repeat (n) send_byte(random_stream_byte());
        end else if (pick < 80) begin
            send_byte(ofsl_pkg::HDR_LINE_0);
            send_byte(ofsl_pkg::HDR_LINE_1);
            repeat (ofsl_pkg::LINE_SKIP_BYTES) send_byte(random_stream_byte());
        end else if (pick < 93) begin
            repeat ($urandom_range(1, 3)) begin
                send_byte(ofsl_pkg::BYTE_W'($urandom_range(0, 255)));
            end
        end else begin
            case ($urandom_range(0, 2))
                0: begin
                    send_byte(ofsl_pkg::HDR_CODE_0);
                    send_byte(ofsl_pkg::HDR_CODE_1 ^ 8'h01);
                end
                1: begin
                    send_byte(ofsl_pkg::BYTE_W'($urandom_range(0, 255)));
                    send_byte(ofsl_pkg::HDR_DATA_0);
                    send_byte(ofsl_pkg::HDR_DATA_1);
                end
                default: begin
                    // The section is cut short, so the next bytes complete it.
                    n = $urandom_range(2, 4);
                    send_byte(ofsl_pkg::HDR_CODE_0);
                    send_byte(ofsl_pkg::HDR_CODE_1);
                    send_word(ofsl_pkg::WORD_W'($urandom));
                    send_word(ofsl_pkg::WORD_W'(n));
                    repeat (n - 1) send_word(ofsl_pkg::WORD_W'($urandom));
                end
            endcase
        end
    endtask

    task automatic test_code_section_wrap();
        send_byte(ofsl_pkg::HDR_CODE_0);
        send_byte(ofsl_pkg::HDR_CODE_1);
        send_word(16'hFFFF);
        send_word(16'h0002);
        send_word(16'h0000);
        send_word(16'hFFFF);
    endtask

    task automatic test_zero_count();
        send_byte(ofsl_pkg::HDR_DATA_0);
        send_byte(ofsl_pkg::HDR_DATA_1);
        send_word(16'h0000);
        send_word(16'h0000);
    endtask

    task automatic test_header_mismatch();
        send_byte(ofsl_pkg::HDR_CODE_0);
        send_byte(ofsl_pkg::HDR_DATA_1);
    endtask

    task automatic test_symbol_section();
        send_byte(ofsl_pkg::HDR_SYM_0);
        send_byte(ofsl_pkg::HDR_SYM_1);
        send_word(16'h00FF);
        send_word(16'h0001);
        send_byte(ofsl_pkg::HDR_CODE_0);
    endtask

    task automatic test_file_name_section();
        send_byte(ofsl_pkg::HDR_FILE_0);
        send_byte(ofsl_pkg::HDR_FILE_1);
        send_word(16'h0000);
    endtask

    task automatic test_line_number_section();
        send_byte(ofsl_pkg::HDR_LINE_0);
        send_byte(ofsl_pkg::HDR_LINE_1);
        send_byte(ofsl_pkg::HDR_DATA_0);
        send_byte(ofsl_pkg::HDR_DATA_1);
        send_byte(8'h80);
        send_byte(8'h7F);
        send_byte(8'h55);
        send_byte(8'hAA);
    endtask

    task automatic test_output_backpressure();
        ready_hold_cycles = HOLD_OFF_CYCLES;
        send_byte(ofsl_pkg::HDR_CODE_0);
        send_byte(ofsl_pkg::HDR_CODE_1);
        send_word(ofsl_pkg::WORD_W'($urandom));
        send_word(16'd40);
        repeat (40) send_word(ofsl_pkg::WORD_W'($urandom));
    endtask

    task automatic test_drain_pause();
        send_byte(ofsl_pkg::HDR_DATA_0);
        send_byte(ofsl_pkg::HDR_DATA_1);
        send_word(ofsl_pkg::WORD_W'($urandom));
        send_word(16'd3);
        repeat (3) send_word(ofsl_pkg::WORD_W'($urandom));
        drain_writes();
        send_byte(ofsl_pkg::HDR_CODE_0);
        send_byte(ofsl_pkg::HDR_CODE_1);
        send_word(ofsl_pkg::WORD_W'($urandom));
        send_word(16'd2);
        repeat (2) send_word(ofsl_pkg::WORD_W'($urandom));
    endtask

    task automatic test_random_stream();
        int stop_at;
        stop_at = bytes_sent + RANDOM_BYTES;
        src_gaps_on   = 1'b1;
        snk_stalls_on = 1'b1;
        while (bytes_sent < stop_at) begin
            if ($urandom_range(0, 11) == 0) begin
                src_gaps_on   = $urandom_range(0, 1);
                snk_stalls_on = $urandom_range(0, 1);
            end
            send_random_section();
        end
    endtask

    task automatic test_full_rate();
        int stop_at;
        stop_at = bytes_sent + FULL_RATE_BYTES;
        src_gaps_on   = 1'b0;
        snk_stalls_on = 1'b0;
        while (bytes_sent < stop_at) begin
            send_random_section();
        end
    endtask

    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall_left == 0 && snk_stalls_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 5);
            end
            if (ready_hold_cycles > 0) begin
                ready_hold_cycles--;
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin : write_checker
        ofsl_pkg::ofsl_write_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_writes.size() == 0) begin
                report_mismatch($sformatf("unexpected write address %h data %h",
                                          m_write_address, m_write_data));
            end else begin
                want = pending_writes.pop_front();
                if (m_write_address !== want.address) begin
                    report_mismatch($sformatf("write address %h, expected %h",
                                              m_write_address, want.address));
                end
                if (m_write_data !== want.data) begin
                    report_mismatch($sformatf("write data %h at %h, expected %h",
                                              m_write_data, want.address, want.data));
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        s_valid       = 1'b0;
        s_stream_byte = '0;
        aresetn       = 1'b0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        src_gaps_on   = 1'b1;
        snk_stalls_on = 1'b1;
        test_code_section_wrap();
        test_zero_count();
        test_header_mismatch();
        test_symbol_section();
        test_file_name_section();
        test_line_number_section();
        test_output_backpressure();
        test_drain_pause();
        test_random_stream();
        test_full_rate();
        drain_writes();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
